/* src/mmt_pkg.sv */
// Shared types and codes for the keyed multimap table.
// No dependencies; imported by mmt_cell and keyed_multimap_table_top.
package mmt_pkg;

	localparam int VALUE_W = 32;
	localparam int PORT_KEY_W = 32;
	localparam int CNT_W = 5;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_FIND = 2'd2;
	localparam logic [1:0] OP_DUMP = 2'd3;

	localparam logic [1:0] ST_ENTRY = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_REMOVED = 2'd3;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic write;     // cell at index fill takes the incoming pair
		logic mark;      // load the pending flag
		logic mark_all;  // with mark: flag every occupied cell, no key compare
		logic compact;   // cells at or after the first pending one take from the right
		logic rotate;    // every cell takes from the right, head wraps to the tail
	} mmt_cmd_t;

endpackage

/* src/mmt_cell.sv */
// One slot of the table chain: key, value and a pending flag.
// Depends on mmt_pkg for the command struct.
module mmt_cell import mmt_pkg::*; #(
	parameter int KEY_BITS = 32,
	parameter int CAPACITY = 16,
	parameter int INDEX = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mmt_cmd_t                             cmd,
	input  logic [$clog2(CAPACITY+1)-1:0]        fill,
	input  logic [KEY_BITS-1:0]                  new_key,
	input  logic signed [VALUE_W-1:0]            new_value,
	input  logic [KEY_BITS-1:0]                  nb_key,
	input  logic signed [VALUE_W-1:0]            nb_value,
	input  logic                                 nb_pend,
	input  logic                                 seen_in,
	output logic                                 seen_out,
	output logic [KEY_BITS-1:0]                  key_q,
	output logic signed [VALUE_W-1:0]            value_q,
	output logic                                 pend_q
);

	localparam int FW = $clog2(CAPACITY+1);

	logic shift_en;
	logic occupied;
	logic hit;

	assign occupied = FW'(INDEX) < fill;
	assign hit = cmd.mark_all || (key_q == new_key);
	// a pending cell anywhere at or left of here closes the gap by one
	assign seen_out = seen_in | pend_q;
	assign shift_en = cmd.rotate | (cmd.compact & seen_out);

	always_ff @(posedge clk) begin
		if (cmd.write && fill == FW'(INDEX)) begin
			key_q <= new_key;
			value_q <= new_value;
		end else if (shift_en) begin
			key_q <= nb_key;
			value_q <= nb_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (cmd.mark) begin
			pend_q <= occupied && hit;
		end else if (shift_en) begin
			pend_q <= nb_pend;
		end
	end

endmodule

/* src/keyed_multimap_table_top.sv */
// Keyed multimap table: ordered key/value pairs in a chain of cells, duplicates allowed.
// Add: result loaded from S_RESP into the output reg. Remove: one entry dropped per cycle in S_RMV, then S_RESP.
// Find/dump: the chain rotates once, one beat per hit as output allows.
// One operation in flight; next beat accepted once the last result sits in the output reg.
// Reset clears fill count, pending flags and output valid; stored pairs are undefined.
module keyed_multimap_table_top import mmt_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    op,
	input  logic [PORT_KEY_W-1:0]         item_key,
	input  logic signed [VALUE_W-1:0]     item_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [PORT_KEY_W-1:0]         out_key,
	output logic signed [VALUE_W-1:0]     out_value,
	output logic [CNT_W-1:0]              removed_count,
	output logic                          last
);

	localparam int FW = $clog2(CAPACITY+1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RMV = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_RESP = 2'd3;

	logic [1:0] state_q, state_d;
	logic [FW-1:0] fill_q, fill_d;
	logic [FW-1:0] step_q, step_d;
	logic [FW-1:0] count_q, count_d;
	logic emitted_q, emitted_d;
	logic [1:0] resp_status_q, resp_status_d;

	logic out_valid_q;
	logic [1:0] status_q;
	logic [PORT_KEY_W-1:0] out_key_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic [CNT_W-1:0] removed_count_q;
	logic last_q;

	mmt_cmd_t cmd;
	logic accept;
	logic slot_free;
	logic out_load_entry;
	logic out_load_resp;

	logic [KEY_BITS-1:0] new_key;
	logic [KEY_BITS-1:0] key_c [CAPACITY];
	logic signed [VALUE_W-1:0] val_c [CAPACITY];
	logic [CAPACITY-1:0] pend_v;
	logic [CAPACITY:0] seen;
	logic rest_pend;

	assign new_key = KEY_BITS'(item_key);
	assign seen[0] = 1'b0;
	assign rest_pend = |(pend_v >> 1);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_BITS-1:0] nb_key;
		logic signed [VALUE_W-1:0] nb_value;
		logic nb_pend;
		if (i < CAPACITY - 1) begin : g_mid
			assign nb_key = key_c[i+1];
			assign nb_value = val_c[i+1];
			assign nb_pend = pend_v[i+1];
		end else begin : g_tail
			// head wraps to the tail already visited
			assign nb_key = key_c[0];
			assign nb_value = val_c[0];
			assign nb_pend = 1'b0;
		end
		mmt_cell #(
			.KEY_BITS(KEY_BITS),
			.CAPACITY(CAPACITY),
			.INDEX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cmd(cmd),
			.fill(fill_q),
			.new_key(new_key),
			.new_value(item_value),
			.nb_key(nb_key),
			.nb_value(nb_value),
			.nb_pend(nb_pend),
			.seen_in(seen[i]),
			.seen_out(seen[i+1]),
			.key_q(key_c[i]),
			.value_q(val_c[i]),
			.pend_q(pend_v[i])
		);
	end

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid & in_ready;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		fill_d = fill_q;
		step_d = step_q;
		count_d = count_q;
		emitted_d = emitted_q;
		resp_status_d = resp_status_q;
		cmd = '0;
		out_load_entry = 1'b0;
		out_load_resp = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					count_d = '0;
					step_d = '0;
					emitted_d = 1'b0;
					case (op)
						OP_ADD: begin
							if (fill_q < FW'(CAPACITY)) begin
								cmd.write = 1'b1;
								fill_d = fill_q + FW'(1);
								resp_status_d = ST_ENTRY;
							end else begin
								resp_status_d = ST_FULL;
							end
							state_d = S_RESP;
						end
						OP_REMOVE: begin
							cmd.mark = 1'b1;
							state_d = S_RMV;
						end
						OP_FIND: begin
							cmd.mark = 1'b1;
							state_d = S_SCAN;
						end
						default: begin
							cmd.mark = 1'b1;
							cmd.mark_all = 1'b1;
							state_d = S_SCAN;
						end
					endcase
				end
			end
			S_RMV: begin
				// drop the first pending entry each cycle
				if (seen[CAPACITY]) begin
					cmd.compact = 1'b1;
					count_d = count_q + FW'(1);
					fill_d = fill_q - FW'(1);
				end else begin
					resp_status_d = ST_REMOVED;
					state_d = S_RESP;
				end
			end
			S_SCAN: begin
				if (step_q == FW'(CAPACITY)) begin
					if (!emitted_q) begin
						resp_status_d = ST_NONE;
						state_d = S_RESP;
					end else begin
						state_d = S_IDLE;
					end
				end else if (pend_v[0]) begin
					if (slot_free) begin
						out_load_entry = 1'b1;
						emitted_d = 1'b1;
						cmd.rotate = 1'b1;
						step_d = step_q + FW'(1);
					end
				end else begin
					cmd.rotate = 1'b1;
					step_d = step_q + FW'(1);
				end
			end
			S_RESP: begin
				if (slot_free) begin
					out_load_resp = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			step_q <= '0;
			count_q <= '0;
			emitted_q <= 1'b0;
			resp_status_q <= ST_ENTRY;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q <= fill_d;
			step_q <= step_d;
			count_q <= count_d;
			emitted_q <= emitted_d;
			resp_status_q <= resp_status_d;
			if (out_load_entry || out_load_resp) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load_entry) begin
			status_q <= ST_ENTRY;
			out_key_q <= PORT_KEY_W'(key_c[0]);
			out_value_q <= val_c[0];
			removed_count_q <= '0;
			last_q <= !rest_pend;
		end else if (out_load_resp) begin
			status_q <= resp_status_q;
			out_key_q <= '0;
			out_value_q <= '0;
			removed_count_q <= CNT_W'(count_q);
			last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign out_key = out_key_q;
	assign out_value = out_value_q;
	assign removed_count = removed_count_q;
	assign last = last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(CAPACITY))
		else $error("fill count beyond capacity");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= FW'(CAPACITY))
		else $error("rotation ran past one full turn");

	a_scan_emit_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && out_load_entry) |-> pend_v[0])
		else $error("scan emitted a head cell that is not a hit");

	a_full_add_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_ADD && fill_q == FW'(CAPACITY)) |=> $stable(fill_q))
		else $error("add to full table changed fill count");

	a_remove_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RMV && seen[CAPACITY]) |=> fill_q == $past(fill_q) - FW'(1))
		else $error("remove step did not drop exactly one entry");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for keyed_multimap_table_top: directed and random add,
// remove, find and dump beats against a behavioral table kept in the bench.
// Depends on mmt_pkg and keyed_multimap_table_top from src.
module testbench;
	import mmt_pkg::*;

	localparam int CAPACITY = 16;
	localparam int KEY_BITS = 32;
	localparam logic [PORT_KEY_W-1:0] ENTRY_KEY_MASK = {PORT_KEY_W{1'b1}} >> (PORT_KEY_W - KEY_BITS);
	localparam int IDLE_PCT = 22;
	localparam int STALL_CYCLES = 300;

	typedef struct packed {
		logic [1:0]             status;
		logic [PORT_KEY_W-1:0]  key;
		logic [VALUE_W-1:0]     value;
		logic [CNT_W-1:0]       removed;
		logic                   last;
	} table_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [1:0]                   op = OP_ADD;
	logic [PORT_KEY_W-1:0]        item_key = '0;
	logic signed [VALUE_W-1:0]    item_value = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [1:0]                   status;
	logic [PORT_KEY_W-1:0]        out_key;
	logic signed [VALUE_W-1:0]    out_value;
	logic [CNT_W-1:0]             removed_count;
	logic                         last;

	// bench copy of the table
	logic [PORT_KEY_W-1:0]  tbl_keys [CAPACITY];
	logic [VALUE_W-1:0]     tbl_vals [CAPACITY];
	int                     tbl_fill = 0;

	table_result_t          expected_beats [$];
	logic [PORT_KEY_W-1:0]  key_pool [5];

	bit  tx_idle_en = 1'b1;
	bit  rx_idle_en = 1'b1;
	int  hold_left = 0;
	int  errors = 0;
	int  beats_checked = 0;
	int  ops_sent [4] = '{0, 0, 0, 0};
	int  full_rejects = 0;
	int  most_hits = 0;

	keyed_multimap_table_top #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.item_key(item_key),
		.item_value(item_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.out_key(out_key),
		.out_value(out_value),
		.removed_count(removed_count),
		.last(last)
	);

	always #4 clk = ~clk;

	function automatic void push_result(input logic [1:0] st, input logic [PORT_KEY_W-1:0] k,
			input logic [VALUE_W-1:0] v, input int rem, input logic lst);
		table_result_t r;
		r.status = st;
		r.key = k;
		r.value = v;
		r.removed = CNT_W'(rem);
		r.last = lst;
		expected_beats = {expected_beats, r};
	endfunction

	// applies one operation to the bench table and queues the beats it should produce
	function automatic void predict_table_op(input logic [1:0] opc, input logic [PORT_KEY_W-1:0] k_in,
			input logic [VALUE_W-1:0] v);
		logic [PORT_KEY_W-1:0] k;
		int kept;
		int lastpos;
		int hits;
		k = k_in & ENTRY_KEY_MASK;
		kept = 0;
		lastpos = -1;
		hits = 0;
		ops_sent[opc]++;
		case (opc)
			OP_ADD: begin
				if (tbl_fill >= CAPACITY) begin
					full_rejects++;
					push_result(ST_FULL, '0, '0, 0, 1'b1);
				end else begin
					tbl_keys[tbl_fill] = k;
					tbl_vals[tbl_fill] = v;
					tbl_fill++;
					push_result(ST_ENTRY, '0, '0, 0, 1'b1);
				end
			end
			OP_REMOVE: begin
				for (int i = 0; i < tbl_fill; i++) begin
					if (tbl_keys[i] != k) begin
						tbl_keys[kept] = tbl_keys[i];
						tbl_vals[kept] = tbl_vals[i];
						kept++;
					end
				end
				push_result(ST_REMOVED, '0, '0, tbl_fill - kept, 1'b1);
				tbl_fill = kept;
			end
			OP_FIND: begin
				for (int i = 0; i < tbl_fill; i++)
					if (tbl_keys[i] == k)
						lastpos = i;
				if (lastpos < 0) begin
					push_result(ST_NONE, '0, '0, 0, 1'b1);
				end else begin
					for (int i = 0; i < tbl_fill; i++) begin
						if (tbl_keys[i] == k) begin
							push_result(ST_ENTRY, tbl_keys[i], tbl_vals[i], 0, i == lastpos);
							hits++;
						end
					end
					if (hits > most_hits)
						most_hits = hits;
				end
			end
			default: begin
				if (tbl_fill == 0)
					push_result(ST_NONE, '0, '0, 0, 1'b1);
				else
					for (int i = 0; i < tbl_fill; i++)
						push_result(ST_ENTRY, tbl_keys[i], tbl_vals[i], 0, i + 1 == tbl_fill);
			end
		endcase
	endfunction

	// called at a rising edge; returns at the edge the beat is taken, valid left high
	task automatic send_beat(input logic [1:0] o, input logic [PORT_KEY_W-1:0] k,
			input logic [VALUE_W-1:0] v);
		if (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		item_key <= k;
		item_value <= v;
		do
			@(posedge clk);
		while (!in_ready);
		predict_table_op(o, k, v);
	endtask

	// sender pauses until every queued beat has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_empty_table();
		send_beat(OP_DUMP, '0, '0);
		send_beat(OP_FIND, 32'hFFFF_FFFF, 32'h1234_5678);
		send_beat(OP_REMOVE, '0, '0);
		drain_results();
	endtask

	task automatic test_basic_ops();
		send_beat(OP_ADD, 32'h0000_0000, 32'h8000_0000);
		send_beat(OP_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_beat(OP_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
		send_beat(OP_FIND, 32'h0000_0000, 32'h5555_5555);
		send_beat(OP_FIND, 32'hFFFF_FFFF, '0);
		send_beat(OP_FIND, 32'h0001_2345, '0);
		send_beat(OP_DUMP, 32'hAAAA_AAAA, '0);
		send_beat(OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain_results();
	endtask

	// fills with one key so find and remove hit every slot
	task automatic test_full_table();
		while (tbl_fill < CAPACITY)
			send_beat(OP_ADD, 32'h0000_0000, $urandom);
		send_beat(OP_ADD, 32'h5A5A_A5A5, $urandom);
		send_beat(OP_DUMP, '0, '0);
		send_beat(OP_FIND, 32'h0000_0000, '0);
		send_beat(OP_REMOVE, 32'h0000_0000, '0);
		drain_results();
	endtask

	task automatic send_random_beat();
		int r;
		logic [1:0] o;
		logic [PORT_KEY_W-1:0] k;
		r = $urandom_range(99);
		if (r < 40)
			o = OP_ADD;
		else if (r < 58)
			o = OP_REMOVE;
		else if (r < 82)
			o = OP_FIND;
		else
			o = OP_DUMP;
		k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(4)] : $urandom;
		send_beat(o, k, $urandom);
	endtask

	task automatic test_random_mix(input int count, input bit idle);
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < 5; i++)
			key_pool[i] = $urandom;
		tx_idle_en = idle;
		rx_idle_en = idle;
		for (int i = 0; i < count; i++)
			send_random_beat();
		drain_results();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// receiver holds off while the sender keeps offering beats
	task automatic test_output_stall();
		hold_left = STALL_CYCLES;
		for (int i = 0; i < 12; i++)
			send_random_beat();
		drain_results();
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (rx_idle_en) begin
			out_ready <= ($urandom_range(99) >= IDLE_PCT);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				$error("result beat with nothing expected: status %0d key %0h", status, out_key);
				errors++;
			end else begin
				want = expected_beats.pop_front();
				compare_field("status", 32'(want.status), 32'(status));
				compare_field("out_key", want.key, out_key);
				compare_field("out_value", want.value, out_value);
				compare_field("removed_count", 32'(want.removed), 32'(removed_count));
				compare_field("last", 32'(want.last), 32'(last));
				beats_checked++;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_basic_ops();
		test_full_table();
		test_random_mix(120, 1'b1);
		test_random_mix(80, 1'b0);
		test_output_stall();
		test_random_mix(90, 1'b1);
		repeat (CAPACITY + 8) @(posedge clk);
		if (expected_beats.size() != 0) begin
			$error("%0d expected result beats never arrived", expected_beats.size());
			errors++;
		end
		$display("Ran %0d add, %0d remove, %0d find, %0d dump; %0d result beats checked.",
			ops_sent[OP_ADD], ops_sent[OP_REMOVE], ops_sent[OP_FIND], ops_sent[OP_DUMP],
			beats_checked);
		$display("Full-table rejects: %0d, most find hits in one beat run: %0d.",
			full_rejects, most_hits);
		if (errors == 0) begin
			$display("** keyed_multimap_table_top: PASSED **");
		end else begin
			$display("** keyed_multimap_table_top: FAILED **");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout with %0d result beats outstanding", expected_beats.size());
		$display("** keyed_multimap_table_top: FAILED **");
		$finish;
	end

endmodule
